FILE: rtl/topic_filter_match_core_defines.svh
// Assertion macros shared by the topic filter matcher RTL.
`ifndef TOPIC_FILTER_MATCH_CORE_DEFINES_SVH
`define TOPIC_FILTER_MATCH_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define TFM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tfm same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define TFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tfm next-cycle check failed");

`endif

FILE: rtl/tfm_pkg.sv
// Types, constants and codes shared by the topic filter matcher modules.
`default_nettype none
package tfm_pkg;

    localparam int FILTER_BYTES  = 256;
    localparam int LEVEL_LIMIT   = 128;
    localparam int TOPIC_MAX_LEN = 65535;
    localparam int FILT_LIMIT    = (FILTER_BYTES < TOPIC_MAX_LEN) ? FILTER_BYTES : TOPIC_MAX_LEN;

    localparam int ADDR_W = $clog2(FILTER_BYTES);
    localparam int FL_W   = $clog2(FILTER_BYTES + 1);
    localparam int LEN_W  = $clog2(TOPIC_MAX_LEN + 1);
    localparam int LVL_W  = $clog2(LEVEL_LIMIT + 1);
    localparam int ERR_W  = 4;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_LOW   = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'h7E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY      = 4'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 4'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR   = 4'd3;
    localparam logic [ERR_W-1:0] ERR_TOPIC_WILD = 4'd4;
    localparam logic [ERR_W-1:0] ERR_LEVELS     = 4'd5;
    localparam logic [ERR_W-1:0] ERR_HASH_POS   = 4'd6;
    localparam logic [ERR_W-1:0] ERR_PARTIAL    = 4'd7;
    localparam logic [ERR_W-1:0] ERR_NO_FILTER  = 4'd8;

    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_TOPIC  = 1'b1;

    typedef enum logic [1:0] {
        MD_CMP,
        MD_SKIP,
        MD_REST,
        MD_FAIL
    } t_mode;

    typedef enum logic {
        BS_RUN,
        BS_FINISH
    } t_bstate;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic       kind;
        logic       first;
        logic       nob;
        logic       last;
        logic [7:0] byte_v;
        logic       bad;
        logic       slash;
        logic       plus;
        logic       hash;
    } t_work;

    typedef struct packed {
        logic             result_of;
        logic             matched;
        logic             topic_ok;
        logic             filter_ok;
        logic [ERR_W-1:0] error_code;
    } t_res;

endpackage
`default_nettype wire

FILE: rtl/tfm_intf.sv
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface tfm_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;

    modport source (output valid, output func, output data_byte, output no_byte,
                    output last, input ready);
    modport sink   (input valid, input func, input data_byte, input no_byte,
                    input last, output ready);
endinterface

interface tfm_res_if;
    logic                      valid;
    logic                      ready;
    logic                      result_of;
    logic                      matched;
    logic                      topic_ok;
    logic                      filter_ok;
    logic [tfm_pkg::ERR_W-1:0] error_code;

    modport source (output valid, output result_of, output matched, output topic_ok,
                    output filter_ok, output error_code, input ready);
    modport sink   (input valid, input result_of, input matched, input topic_ok,
                    input filter_ok, input error_code, output ready);
endinterface
`default_nettype wire

FILE: rtl/tfm_front.sv
// Front end: accepts input words, tracks string boundaries and classifies bytes.
`default_nettype none
module tfm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tfm_item_if.sink       i_item,
    input  logic           i_push_ready,
    output logic           o_push,
    output tfm_pkg::t_work o_work
);
    import tfm_pkg::*;

    logic r_busy;
    logic r_kind;
    logic n_busy;
    logic n_kind;
    logic ignore;
    logic take;

    // An empty word that does not end a string outside of any string is dropped.
    assign ignore       = !r_busy && i_item.no_byte && !i_item.last;
    assign i_item.ready = i_push_ready;
    assign take         = i_item.valid && i_push_ready;
    assign o_push       = take && !ignore;

    always_comb begin
        o_work.kind   = r_busy ? r_kind : i_item.func;
        o_work.first  = !r_busy;
        o_work.nob    = i_item.no_byte;
        o_work.last   = i_item.last;
        o_work.byte_v = i_item.data_byte;
        o_work.bad    = (i_item.data_byte < CH_LOW) || (i_item.data_byte > CH_HIGH);
        o_work.slash  = (i_item.data_byte == CH_SLASH);
        o_work.plus   = (i_item.data_byte == CH_PLUS);
        o_work.hash   = (i_item.data_byte == CH_HASH);
    end

    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        if (o_push) begin
            n_busy = !i_item.last;
            n_kind = o_work.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= KIND_FILTER;
        end else begin
            r_busy <= n_busy;
            r_kind <= n_kind;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tfm_fifo.sv
// Short queue of classified words between the front and the back.
`default_nettype none
module tfm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tfm_pkg::t_work i_work,
    output logic           o_push_ready,
    input  logic           i_pop,
    output logic           o_pop_valid,
    output tfm_pkg::t_work o_work
);
    import tfm_pkg::*;

    t_work            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_push_ready = (r_cnt != CNT_W'(FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_work       = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tfm_back.sv
// Back end: filter store, validation, level-by-level matching and the result register.
`default_nettype none
`include "topic_filter_match_core_defines.svh"
module tfm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tfm_pkg::t_work i_q_work,
    output logic           o_q_pop,
    tfm_res_if.source      o_res
);
    import tfm_pkg::*;

    logic [7:0]       r_store [FILTER_BYTES];
    logic [7:0]       r_rd;

    t_bstate          r_state;
    t_bstate          n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    t_res             r_out;
    t_res             n_out;

    logic [FL_W-1:0]  r_fl;
    logic [FL_W-1:0]  n_fl;
    logic             r_fvalid;
    logic             n_fvalid;
    logic             r_hash_end;
    logic             n_hash_end;

    logic             r_kind;
    logic             n_kind;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [FL_W-1:0]  r_lvl_start;
    logic [FL_W-1:0]  n_lvl_start;
    logic [LVL_W-1:0] r_lvl_cnt;
    logic [LVL_W-1:0] n_lvl_cnt;
    logic [7:0]       r_lvl_ch;
    logic [7:0]       n_lvl_ch;
    logic [ERR_W-1:0] r_perr;
    logic [ERR_W-1:0] n_perr;
    logic [FL_W-1:0]  r_cursor;
    logic [FL_W-1:0]  n_cursor;
    t_mode            r_mode;
    t_mode            n_mode;
    logic             r_fresh;
    logic             n_fresh;
    logic             r_bad;
    logic             n_bad;
    logic             r_long;
    logic             n_long;
    logic             r_wild;
    logic             n_wild;

    logic             mem_we;
    logic             slot_free;
    logic             do_item;
    logic             finish_go;
    logic             have;
    logic [FL_W:0]    cur1;
    logic [FL_W:0]    cur2;
    logic [FL_W:0]    cur3;
    logic [FL_W-1:0]  pos;
    logic [FL_W-1:0]  lvl_len;
    logic [ERR_W-1:0] err;
    logic             end_hit;

    assign slot_free = !r_out_valid || o_res.ready;
    assign do_item   = (r_state == BS_RUN) && i_q_valid;
    assign finish_go = (r_state == BS_FINISH) && slot_free;
    assign o_q_pop   = do_item;

    assign have = (r_cursor < r_fl);
    assign cur1 = {1'b0, r_cursor} + (FL_W+1)'(1);
    assign cur2 = {1'b0, r_cursor} + (FL_W+1)'(2);
    assign cur3 = {1'b0, r_cursor} + (FL_W+1)'(3);
    assign pos  = r_len[FL_W-1:0];

    assign o_res.valid      = r_out_valid;
    assign o_res.result_of  = r_out.result_of;
    assign o_res.matched    = r_out.matched;
    assign o_res.topic_ok   = r_out.topic_ok;
    assign o_res.filter_ok  = r_out.filter_ok;
    assign o_res.error_code = r_out.error_code;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_RUN: begin
                if (do_item && i_q_work.last) begin
                    n_state = BS_FINISH;
                end
            end
            BS_FINISH: begin
                if (slot_free) begin
                    n_state = BS_RUN;
                end
            end
            default: n_state = BS_RUN;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        n_fl        = r_fl;
        n_fvalid    = r_fvalid;
        n_hash_end  = r_hash_end;
        n_kind      = r_kind;
        n_len       = r_len;
        n_lvl_start = r_lvl_start;
        n_lvl_cnt   = r_lvl_cnt;
        n_lvl_ch    = r_lvl_ch;
        n_perr      = r_perr;
        n_cursor    = r_cursor;
        n_mode      = r_mode;
        n_fresh     = r_fresh;
        n_bad       = r_bad;
        n_long      = r_long;
        n_wild      = r_wild;
        mem_we      = 1'b0;
        lvl_len     = '0;
        err         = ERR_NONE;
        end_hit     = 1'b0;

        if (do_item) begin
            n_kind = i_q_work.kind;
            if (i_q_work.first && (i_q_work.kind == KIND_FILTER)) begin
                n_fvalid   = 1'b0;
                n_fl       = '0;
                n_hash_end = 1'b0;
            end
            if (!i_q_work.nob && (i_q_work.kind == KIND_FILTER) && !r_long) begin
                if (r_len >= LEN_W'(FILT_LIMIT)) begin
                    n_long = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    n_fl   = pos + 1'b1;
                    n_len  = r_len + 1'b1;
                    if (i_q_work.bad) begin
                        n_bad = 1'b1;
                    end
                    if (pos == r_lvl_start) begin
                        n_lvl_ch = i_q_work.byte_v;
                    end
                    if (i_q_work.slash) begin
                        lvl_len = pos - r_lvl_start;
                        if (lvl_len == FL_W'(1)) begin
                            if (r_lvl_ch == CH_HASH && n_perr == ERR_NONE) begin
                                n_perr = ERR_HASH_POS;
                            end
                        end else if (lvl_len > FL_W'(1) && r_wild && n_perr == ERR_NONE) begin
                            n_perr = ERR_PARTIAL;
                        end
                        n_wild = 1'b0;
                        if (r_lvl_cnt >= LVL_W'(LEVEL_LIMIT)) begin
                            if (n_perr == ERR_NONE) begin
                                n_perr = ERR_LEVELS;
                            end
                        end else begin
                            n_lvl_cnt = r_lvl_cnt + 1'b1;
                        end
                        n_lvl_start = pos + 1'b1;
                    end else if (i_q_work.plus || i_q_work.hash) begin
                        n_wild = 1'b1;
                    end
                end
            end else if (!i_q_work.nob && (i_q_work.kind == KIND_TOPIC) && !r_long) begin
                if (r_len >= LEN_W'(TOPIC_MAX_LEN)) begin
                    n_long = 1'b1;
                    n_mode = MD_FAIL;
                end else begin
                    n_len = r_len + 1'b1;
                    if (i_q_work.bad) begin
                        n_bad = 1'b1;
                    end
                    if (i_q_work.plus || i_q_work.hash) begin
                        if (n_perr == ERR_NONE || ERR_TOPIC_WILD < n_perr) begin
                            n_perr = ERR_TOPIC_WILD;
                        end
                    end
                    if (i_q_work.slash) begin
                        if (r_lvl_cnt >= LVL_W'(LEVEL_LIMIT)) begin
                            if (n_perr == ERR_NONE || ERR_LEVELS < n_perr) begin
                                n_perr = ERR_LEVELS;
                            end
                        end else begin
                            n_lvl_cnt = r_lvl_cnt + 1'b1;
                        end
                    end
                    // One store read per byte: r_rd holds the entry under the cursor.
                    unique case (r_mode)
                        MD_REST, MD_FAIL: begin
                        end
                        MD_SKIP: begin
                            if (i_q_work.slash) begin
                                if (have && r_rd == CH_SLASH) begin
                                    n_cursor = r_cursor + 1'b1;
                                    n_mode   = MD_CMP;
                                    n_fresh  = 1'b1;
                                end else begin
                                    n_mode = MD_FAIL;
                                end
                            end
                        end
                        MD_CMP: begin
                            if (r_fresh && have && r_rd == CH_HASH) begin
                                n_mode = MD_REST;
                            end else if (r_fresh && have && r_rd == CH_PLUS) begin
                                n_cursor = r_cursor + 1'b1;
                                n_fresh  = 1'b0;
                                n_mode   = MD_SKIP;
                                if (i_q_work.slash) begin
                                    // In a valid filter a lone '+' that is not the last level is followed by '/'.
                                    if (cur1 < {1'b0, r_fl}) begin
                                        n_cursor = cur2[FL_W-1:0];
                                        n_mode   = MD_CMP;
                                        n_fresh  = 1'b1;
                                    end else begin
                                        n_mode = MD_FAIL;
                                    end
                                end
                            end else if (i_q_work.slash) begin
                                if (have && r_rd == CH_SLASH) begin
                                    n_cursor = r_cursor + 1'b1;
                                    n_mode   = MD_CMP;
                                    n_fresh  = 1'b1;
                                end else begin
                                    n_mode = MD_FAIL;
                                end
                            end else if (have && r_rd == i_q_work.byte_v) begin
                                n_cursor = r_cursor + 1'b1;
                                n_fresh  = 1'b0;
                            end else begin
                                n_mode = MD_FAIL;
                            end
                        end
                        default: n_mode = MD_FAIL;
                    endcase
                end
            end
        end else if (finish_go) begin
            if (r_kind == KIND_FILTER) begin
                if (!r_long && r_len != '0) begin
                    lvl_len = pos - r_lvl_start;
                    if (lvl_len == FL_W'(1)) begin
                        if (r_lvl_ch == CH_HASH) begin
                            n_hash_end = (r_lvl_start != '0);
                        end
                    end else if (lvl_len > FL_W'(1) && r_wild && n_perr == ERR_NONE) begin
                        n_perr = ERR_PARTIAL;
                    end
                end
            end
            if (r_len == '0 && !r_long) begin
                err = ERR_EMPTY;
            end else if (r_long) begin
                err = ERR_TOO_LONG;
            end else if (r_bad) begin
                err = ERR_BAD_CHAR;
            end else begin
                err = n_perr;
            end
            if (r_kind == KIND_FILTER) begin
                n_fvalid         = (err == ERR_NONE);
                n_out.result_of  = KIND_FILTER;
                n_out.matched    = 1'b0;
                n_out.topic_ok   = 1'b0;
                n_out.filter_ok  = (err == ERR_NONE);
                n_out.error_code = err;
            end else begin
                // End of topic: the filter must be used up, or end in a lone '#' level.
                priority case (r_mode)
                    MD_REST: end_hit = 1'b1;
                    MD_FAIL: end_hit = 1'b0;
                    default: begin
                        if (r_mode == MD_CMP && r_fresh && have && r_rd == CH_HASH) begin
                            end_hit = 1'b1;
                        end else if (r_mode == MD_CMP && r_fresh && have && r_rd == CH_PLUS) begin
                            end_hit = (cur1 >= {1'b0, r_fl})
                                   || (r_hash_end && cur3 == {1'b0, r_fl});
                        end else begin
                            end_hit = !have || (r_hash_end && cur2 == {1'b0, r_fl});
                        end
                    end
                endcase
                n_out.result_of  = KIND_TOPIC;
                n_out.matched    = (err == ERR_NONE) && r_fvalid && end_hit;
                n_out.topic_ok   = (err == ERR_NONE);
                n_out.filter_ok  = r_fvalid;
                n_out.error_code = (err != ERR_NONE) ? err
                                 : (r_fvalid ? ERR_NONE : ERR_NO_FILTER);
            end
            n_out_valid = 1'b1;
            n_len       = '0;
            n_lvl_start = '0;
            n_lvl_cnt   = LVL_W'(1);
            n_perr      = ERR_NONE;
            n_cursor    = '0;
            n_mode      = MD_CMP;
            n_fresh     = 1'b1;
            n_bad       = 1'b0;
            n_long      = 1'b0;
            n_wild      = 1'b0;
        end
    end

    // Filter store: written during filter loads, read ahead at the next cursor.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[pos[ADDR_W-1:0]] <= i_q_work.byte_v;
        end
        r_rd <= r_store[n_cursor[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_lvl_ch <= n_lvl_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_RUN;
            r_out_valid <= 1'b0;
            r_fl        <= '0;
            r_fvalid    <= 1'b0;
            r_hash_end  <= 1'b0;
            r_kind      <= KIND_FILTER;
            r_len       <= '0;
            r_lvl_start <= '0;
            r_lvl_cnt   <= LVL_W'(1);
            r_perr      <= ERR_NONE;
            r_cursor    <= '0;
            r_mode      <= MD_CMP;
            r_fresh     <= 1'b1;
            r_bad       <= 1'b0;
            r_long      <= 1'b0;
            r_wild      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fl        <= n_fl;
            r_fvalid    <= n_fvalid;
            r_hash_end  <= n_hash_end;
            r_kind      <= n_kind;
            r_len       <= n_len;
            r_lvl_start <= n_lvl_start;
            r_lvl_cnt   <= n_lvl_cnt;
            r_perr      <= n_perr;
            r_cursor    <= n_cursor;
            r_mode      <= n_mode;
            r_fresh     <= n_fresh;
            r_bad       <= n_bad;
            r_long      <= n_long;
            r_wild      <= n_wild;
        end
    end

    `TFM_ASSERT_IMP(a_cursor_in_filter, i_clk, i_rst_n, 1'b1, r_cursor <= r_fl)
    `TFM_ASSERT_NEXT(a_finish_emits, i_clk, i_rst_n, finish_go, r_out_valid && (r_state == BS_RUN))
    `TFM_ASSERT_IMP(a_valid_filter_nonempty, i_clk, i_rst_n, r_fvalid, r_fl != '0)

endmodule
`default_nettype wire

FILE: rtl/topic_filter_match_core.sv
// Top level of the topic filter matcher: front end, word queue and back end.
`default_nettype none
// Topic filter matcher. Load a subscription filter by sending its bytes with func = 0,
// the final word marked by last; then send topic strings with func = 1. One result word
// comes out for each string, on its final word: for a filter, whether it is valid and its
// error code; for a topic, match, topic validity, filter validity and the error code.
// A '+' level of the filter matches exactly one topic level, possibly empty, and a '#'
// level matches the rest of the topic, including no level. Throughput is one input word
// per clock while the queue has room; each string then costs an extra back-end finish
// step at its end, because the end-of-topic decision needs the filter store entry under
// the final cursor and the store has a single registered read port. A two-word queue
// separates the accepting front end from the back end, and the result sits in an output
// register, so input keeps flowing while a result waits to be taken. The filter store
// needs no clearing after reset.
module topic_filter_match_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfm_item_if.sink  i_item,
    tfm_res_if.source o_res
);
    import tfm_pkg::*;

    // Front to queue.
    logic  push;
    logic  push_ready;
    t_work front_work;

    // Queue to back.
    logic  q_valid;
    logic  q_pop;
    t_work q_work;

    // The front end decides string kind and boundaries and classifies each byte.
    tfm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_work       (front_work)
    );

    // The queue lets the front keep accepting while the back finishes a string.
    tfm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_work       (front_work),
        .o_push_ready (push_ready),
        .i_pop        (q_pop),
        .o_pop_valid  (q_valid),
        .o_work       (q_work)
    );

    // The back end holds the filter and does validation, matching and results.
    tfm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_work  (q_work),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

FILE: bench/tb_topic_filter_match_core.sv
// Self-checking testbench of the topic filter matcher: directed table, then random strings.
`default_nettype none
module tb_topic_filter_match_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tfm_pkg::*;

    // One input word as the sender queues it, with an optional typed expectation
    // and a hold flag that makes the sender wait until the block has drained.
    typedef struct {
        logic       func;
        logic [7:0] data_byte;
        logic       no_byte;
        logic       last;
        bit         typed;
        t_res       typed_res;
        bit         hold;
    } t_word;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 12;

    logic i_clk;
    logic i_rst_n;
    tfm_item_if item_ch ();
    tfm_res_if  res_ch ();

    topic_filter_match_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- Matcher prediction ----------------
    logic [9:0] flt_store [FILTER_BYTES];
    int   flt_len;
    bit   flt_valid;
    logic [3:0] flt_err;
    int   str_len, lvl_start, lvl_count, pend_err, flt_cur;
    t_mode mode;
    bit   in_string, is_topic, saw_bad, over_len, lvl_wild, at_lvl_start;

    function automatic bit in_filter(int i);
        return i < flt_len && i < FILTER_BYTES;
    endfunction

    function automatic logic [9:0] flt_entry(int i);
        return in_filter(i) ? flt_store[i] : 10'd0;
    endfunction

    function automatic void note_err(int code);
        if (pend_err == 0 || (is_topic && code < pend_err)) pend_err = code;
    endfunction

    function automatic void clear_string();
        in_string = 0; is_topic = 0; saw_bad = 0; over_len = 0; lvl_wild = 0;
        at_lvl_start = 1;
        str_len = 0; lvl_start = 0; lvl_count = 1; pend_err = 0; flt_cur = 0;
        mode = MD_CMP;
    endfunction

    function automatic void close_level(bit at_end, int pos);
        logic [7:0] ch;
        int n;
        n = pos - lvl_start;
        if (n == 1 && lvl_start < FILTER_BYTES) begin
            ch = flt_store[lvl_start][7:0];
            if (ch == CH_HASH) begin
                if (!at_end) note_err(ERR_HASH_POS);
                else begin
                    flt_store[lvl_start][9] = 1'b1;
                    if (lvl_start > 0) flt_store[lvl_start-1][9] = 1'b1;
                end
            end else if (ch == CH_PLUS) begin
                flt_store[lvl_start][8] = 1'b1;
            end
        end else if (n > 1 && lvl_wild) begin
            note_err(ERR_PARTIAL);
        end
        lvl_wild = 0;
        if (!at_end) begin
            if (lvl_count >= LEVEL_LIMIT) note_err(ERR_LEVELS); else lvl_count++;
            lvl_start = pos + 1;
        end
    endfunction

    function automatic void filter_char(logic [7:0] c);
        int pos;
        if (over_len) return;
        if (str_len >= FILT_LIMIT) begin
            over_len = 1;
            return;
        end
        pos = str_len;
        if (c < CH_LOW || c > CH_HIGH) saw_bad = 1;
        flt_store[pos] = {2'b00, c};
        flt_len = pos + 1;
        str_len = pos + 1;
        if (c == CH_SLASH) close_level(0, pos);
        else if (c == CH_PLUS || c == CH_HASH) lvl_wild = 1;
    endfunction

    function automatic void leave_level();
        logic [9:0] e;
        e = flt_entry(flt_cur);
        if (in_filter(flt_cur) && e[7:0] == CH_SLASH) begin
            flt_cur++;
            mode = MD_CMP;
            at_lvl_start = 1;
        end else begin
            mode = MD_FAIL;
        end
    endfunction

    function automatic void match_char(logic [7:0] c);
        logic [9:0] e;
        bit h;
        e = flt_entry(flt_cur);
        h = in_filter(flt_cur);
        if (mode == MD_REST || mode == MD_FAIL) return;
        if (mode == MD_SKIP) begin
            if (c == CH_SLASH) leave_level();
            return;
        end
        if (at_lvl_start && h && e[7:0] == CH_HASH && e[9]) begin
            mode = MD_REST;
            return;
        end
        if (at_lvl_start && h && e[7:0] == CH_PLUS && e[8]) begin
            flt_cur++;
            at_lvl_start = 0;
            mode = MD_SKIP;
            if (c == CH_SLASH) leave_level();
            return;
        end
        if (c == CH_SLASH) begin
            leave_level();
            return;
        end
        if (h && e[7:0] == c) begin
            flt_cur++;
            at_lvl_start = 0;
        end else begin
            mode = MD_FAIL;
        end
    endfunction

    function automatic void topic_char(logic [7:0] c);
        if (over_len) return;
        if (str_len >= TOPIC_MAX_LEN) begin
            over_len = 1;
            mode = MD_FAIL;
            return;
        end
        str_len++;
        if (c < CH_LOW || c > CH_HIGH) saw_bad = 1;
        if (c == CH_PLUS || c == CH_HASH) note_err(ERR_TOPIC_WILD);
        if (c == CH_SLASH) begin
            if (lvl_count >= LEVEL_LIMIT) note_err(ERR_LEVELS); else lvl_count++;
        end
        match_char(c);
    endfunction

    // The end of the topic matches if the filter is used up, or only a
    // trailing "/#" remains.
    function automatic bit tail_ok(int fc);
        logic [9:0] e;
        if (!in_filter(fc)) return 1;
        e = flt_entry(fc);
        return e[7:0] == CH_SLASH && e[9];
    endfunction

    function automatic bit topic_matches();
        logic [9:0] e;
        e = flt_entry(flt_cur);
        if (mode == MD_REST) return 1;
        if (mode == MD_FAIL) return 0;
        if (mode == MD_CMP && at_lvl_start && in_filter(flt_cur)) begin
            if (e[7:0] == CH_HASH && e[9]) return 1;
            if (e[7:0] == CH_PLUS && e[8]) return tail_ok(flt_cur + 1);
        end
        return tail_ok(flt_cur);
    endfunction

    function automatic logic [3:0] string_err();
        if (str_len == 0 && !over_len) return ERR_EMPTY;
        if (over_len) return ERR_TOO_LONG;
        if (saw_bad) return ERR_BAD_CHAR;
        return pend_err[3:0];
    endfunction

    // Advances the matcher by one accepted word; returns 1 when a result is due.
    function automatic bit match_step(t_word w, output t_res r);
        logic [3:0] err;
        r = '0;
        if (!in_string) begin
            if (w.no_byte && !w.last) return 0;
            in_string = 1;
            is_topic = w.func;
            if (!is_topic) begin
                flt_valid = 0;
                flt_err = ERR_NO_FILTER;
                flt_len = 0;
            end
        end
        if (!w.no_byte) begin
            if (is_topic) topic_char(w.data_byte); else filter_char(w.data_byte);
        end
        if (!w.last) return 0;
        if (!is_topic) begin
            if (!over_len && str_len > 0) close_level(1, str_len);
            err = string_err();
            flt_err = err;
            flt_valid = (err == ERR_NONE);
            r.result_of = KIND_FILTER;
            r.filter_ok = flt_valid;
            r.error_code = err;
        end else begin
            err = string_err();
            r.result_of = KIND_TOPIC;
            r.matched = (err == ERR_NONE) && flt_valid && topic_matches();
            r.topic_ok = (err == ERR_NONE);
            r.filter_ok = flt_valid;
            r.error_code = (err != ERR_NONE) ? err : (flt_valid ? ERR_NONE : ERR_NO_FILTER);
        end
        clear_string();
        return 1;
    endfunction

    // ---------------- Stimulus store ----------------
    t_word words_q[$];
    t_res  pending_res_q[$];
    int    mismatches = 0;

    function automatic void push_word(logic func, logic [7:0] b, logic nob, logic last,
                                      bit hold);
        t_word w;
        w.func = func; w.data_byte = b; w.no_byte = nob; w.last = last;
        w.typed = 0; w.typed_res = '0; w.hold = hold;
        words_q.push_back(w);
    endfunction

    // Queues a whole string; an empty one becomes a single no_byte word.
    // Ignored empty words and flipped func bits are sprinkled into the body.
    function automatic void push_string(logic kind, logic [7:0] s[$], bit hold);
        logic [7:0] junk;
        logic f;
        if (s.size() == 0) begin
            push_word(kind, 8'($urandom), 1'b1, 1'b1, hold);
            return;
        end
        foreach (s[i]) begin
            f = kind;
            if (i > 0 && $urandom_range(0, 19) == 0) f = ~kind;
            if (i > 0 && $urandom_range(0, 29) == 0) begin
                junk = 8'($urandom);
                push_word(f, junk, 1'b1, 1'b0, 1'b0);
            end
            push_word(f, s[i], 1'b0, (i == s.size() - 1), hold && i == 0);
        end
    endfunction

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return "c";
            default: return 8'($urandom_range(32'h20, 32'h7E));
        endcase
    endfunction

    // Well-formed filters use lone wildcards only; broken ones misplace a wildcard, hold a random byte or are empty.
    function automatic void make_filter(output logic [7:0] s[$]);
        int nlev, len;
        s = {};
        nlev = $urandom_range(1, 4);
        for (int l = 0; l < nlev; l++) begin
            if (l > 0) s.push_back(CH_SLASH);
            case ($urandom_range(0, 9))
                0, 1: s.push_back(CH_PLUS);
                2: if (l == nlev - 1) s.push_back(CH_HASH);
                3: ;
                default: begin
                    len = $urandom_range(1, 2);
                    for (int k = 0; k < len; k++) s.push_back("a" + 8'($urandom_range(0, 2)));
                end
            endcase
        end
        case ($urandom_range(0, 11))
            0: s.insert($urandom_range(0, s.size()), CH_HASH);
            1: s.insert($urandom_range(0, s.size()), CH_PLUS);
            2: s.insert($urandom_range(0, s.size()), 8'($urandom));
            3: s = {};
            default: ;
        endcase
    endfunction

    function automatic void make_topic(output logic [7:0] s[$]);
        int nlev, len;
        s = {};
        nlev = $urandom_range(1, 5);
        for (int l = 0; l < nlev; l++) begin
            if (l > 0) s.push_back(CH_SLASH);
            len = $urandom_range(0, 2);
            for (int k = 0; k < len; k++) s.push_back("a" + 8'($urandom_range(0, 2)));
        end
        case ($urandom_range(0, 15))
            0: s.insert($urandom_range(0, s.size()), 8'($urandom));
            1: s.insert($urandom_range(0, s.size()), ($urandom_range(0, 1)) ? CH_PLUS : CH_HASH);
            2: s = {};
            3: begin
                s = {};
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) s.push_back(pick_name_char());
            end
            default: ;
        endcase
    endfunction

    // Directed rows: {func, byte, no_byte, last, typed, expected result}.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       no_byte;
        logic       last;
        logic       typed;
        t_res       res;
    } t_row;

    function automatic t_row row(logic func, logic [7:0] b, logic nob, logic last,
                                 logic typed, t_res res);
        return {func, b, nob, last, typed, res};
    endfunction

    task automatic build_stimulus();
        t_row rows[$];
        t_word w;
        logic [7:0] s[$];
        int n;
        rows = {
            // After reset: empty topic, then topics with no filter loaded, then an empty filter and two with bad bytes.
            row(KIND_TOPIC, 8'hA5, 1, 1, 1, {KIND_TOPIC, 1'b0, 1'b0, 1'b0, ERR_EMPTY}),
            row(KIND_TOPIC, "a", 0, 1, 1, {KIND_TOPIC, 1'b0, 1'b1, 1'b0, ERR_NO_FILTER}),
            row(KIND_TOPIC, CH_PLUS, 0, 1, 1, {KIND_TOPIC, 1'b0, 1'b0, 1'b0, ERR_TOPIC_WILD}),
            row(KIND_FILTER, 8'h5A, 1, 1, 1, {KIND_FILTER, 1'b0, 1'b0, 1'b0, ERR_EMPTY}),
            row(KIND_FILTER, 8'h1F, 0, 1, 1, {KIND_FILTER, 1'b0, 1'b0, 1'b0, ERR_BAD_CHAR}),
            row(KIND_FILTER, 8'h7F, 0, 1, 1, {KIND_FILTER, 1'b0, 1'b0, 1'b0, ERR_BAD_CHAR}),
            // A '#' level that is not the last one.
            row(KIND_FILTER, CH_HASH, 0, 0, 0, '0),
            row(KIND_FILTER, CH_SLASH, 0, 0, 0, '0),
            row(KIND_FILTER, "a", 0, 1, 1, {KIND_FILTER, 1'b0, 1'b0, 1'b0, ERR_HASH_POS}),
            // A wildcard sharing its level with another character.
            row(KIND_FILTER, "a", 0, 0, 0, '0),
            row(KIND_FILTER, CH_PLUS, 0, 1, 1, {KIND_FILTER, 1'b0, 1'b0, 1'b0, ERR_PARTIAL}),
            // Valid filter a/+/#.
            row(KIND_FILTER, "a", 0, 0, 0, '0),
            row(KIND_FILTER, CH_SLASH, 0, 0, 0, '0),
            row(KIND_FILTER, CH_PLUS, 0, 0, 0, '0),
            row(KIND_FILTER, CH_SLASH, 0, 0, 0, '0),
            row(KIND_FILTER, CH_HASH, 0, 1, 1, {KIND_FILTER, 1'b0, 1'b0, 1'b1, ERR_NONE}),
            // Topic a/x/y against it.
            row(KIND_TOPIC, "a", 0, 0, 0, '0),
            row(KIND_TOPIC, CH_SLASH, 0, 0, 0, '0),
            row(KIND_TOPIC, "x", 0, 0, 0, '0),
            row(KIND_TOPIC, CH_SLASH, 0, 0, 0, '0),
            row(KIND_TOPIC, "y", 0, 1, 0, '0),
            // Kind flip and an empty word inside a topic are both ignored.
            row(KIND_TOPIC, "a", 0, 0, 0, '0),
            row(KIND_FILTER, CH_SLASH, 0, 0, 0, '0),
            row(KIND_TOPIC, 8'hFF, 1, 0, 0, '0),
            row(KIND_TOPIC, 8'hFF, 0, 1, 1, {KIND_TOPIC, 1'b0, 1'b0, 1'b1, ERR_BAD_CHAR})
        };
        foreach (rows[i]) begin
            w.func = rows[i].func; w.data_byte = rows[i].data_byte;
            w.no_byte = rows[i].no_byte; w.last = rows[i].last;
            w.typed = rows[i].typed; w.typed_res = rows[i].res; w.hold = 0;
            words_q.push_back(w);
        end

        // Random strings, with a filter reload every few topics. The limit
        // strings below add roughly another eleven hundred words.
        n = 0;
        while (words_q.size() < 830) begin
            if (n % 6 == 0 || $urandom_range(0, 9) == 0) begin
                make_filter(s);
                push_string(KIND_FILTER, s, n % 200 == 0);
            end else begin
                make_topic(s);
                push_string(KIND_TOPIC, s, 0);
            end
            n++;
        end

        // Length and level limits: too many filter levels, an over-long filter,
        // a filter of the largest length, then topics just over and at the level limit.
        s = {};
        repeat (LEVEL_LIMIT + 1) s.push_back(CH_SLASH);
        push_string(KIND_FILTER, s, 1);
        s = {};
        repeat (FILT_LIMIT + 3) s.push_back("a");
        push_string(KIND_FILTER, s, 0);
        s = {};
        repeat (FILT_LIMIT) s.push_back("a");
        push_string(KIND_FILTER, s, 0);
        s = {};
        repeat (LEVEL_LIMIT) s.push_back(CH_SLASH);
        push_string(KIND_TOPIC, s, 0);
        s = {};
        repeat (LEVEL_LIMIT - 1) s.push_back(CH_SLASH);
        push_string(KIND_TOPIC, s, 0);
        s = {"a", CH_SLASH, CH_HASH};
        push_string(KIND_FILTER, s, 0);
        for (int k = 0; k < 40; k++) begin
            make_topic(s);
            push_string(KIND_TOPIC, s, 0);
        end
    endtask

    // ---------------- Sampling at the rising edge ----------------
    t_word cur_word;
    bit    word_taken = 0;
    int    idle_cycles = 0;

    always @(posedge i_clk) begin
        t_res pred, got, want;
        bit   due;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                due = match_step(cur_word, pred);
                if (due) pending_res_q.push_back(cur_word.typed ? cur_word.typed_res : pred);
                word_taken = 1;
                idle_cycles = 0;
            end else if (!(res_ch.valid && res_ch.ready)) begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
            if (res_ch.valid && res_ch.ready) begin
                idle_cycles = 0;
                got = '{res_ch.result_of, res_ch.matched, res_ch.topic_ok,
                        res_ch.filter_ok, res_ch.error_code};
                if (pending_res_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %p", got);
                end else begin
                    want = pending_res_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // ---------------- Driving at the falling edge ----------------
    int burst_left = 0;
    int gap_left = 0;
    int drain_left = 0;
    logic [15:0] ready_pat = 16'hFFFF;
    int pat_left = 0;
    int pat_pos = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // Receiver: a stall pattern that changes now and then.
            if (pat_left == 0) begin
                pat_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: ready_pat = 16'hFFFF;
                    1: ready_pat = 16'h0001;
                    default: ready_pat = 16'($urandom);
                endcase
                if (ready_pat == 16'h0) ready_pat = 16'h8000;
            end
            pat_left--;
            pat_pos = (pat_pos + 1) % 16;
            res_ch.ready <= ready_pat[pat_pos];

            // Sender: bursts and gaps, plus a drain wait on marked words.
            if (!item_ch.valid || word_taken) begin
                word_taken = 0;
                if (pending_res_q.size() != 0) drain_left = DRAIN_CYCLES;
                else if (drain_left > 0) drain_left--;
                if (gap_left > 0) begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end else if (words_q.size() == 0) begin
                    item_ch.valid <= 1'b0;
                end else if (words_q[0].hold && (pending_res_q.size() != 0 || drain_left > 0)) begin
                    item_ch.valid <= 1'b0;
                end else begin
                    cur_word = words_q.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.func <= cur_word.func;
                    item_ch.data_byte <= cur_word.data_byte;
                    item_ch.no_byte <= cur_word.no_byte;
                    item_ch.last <= cur_word.last;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    burst_left--;
                end
            end
        end
    end

    initial begin
        item_ch.valid = 1'b0;
        item_ch.func = KIND_FILTER;
        item_ch.data_byte = 8'h00;
        item_ch.no_byte = 1'b0;
        item_ch.last = 1'b0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        flt_len = 0;
        flt_valid = 0;
        flt_err = ERR_NO_FILTER;
        clear_string();
        build_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Run until every word is sent and every result is in, then let the
        // pipeline settle so a stray result word would still be caught.
        while (words_q.size() != 0 || item_ch.valid || pending_res_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_res_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/tfm_pkg.sv
rtl/tfm_intf.sv
rtl/tfm_front.sv
rtl/tfm_fifo.sv
rtl/tfm_back.sv
rtl/topic_filter_match_core.sv
bench/tb_topic_filter_match_core.sv
